### rtl/heightmap_normal_stencil_macros.svh
// ----------------------------------------------------------------------------
// heightmap_normal_stencil_macros
// Assertion macros for the height map normal block.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_NORMAL_STENCIL_MACROS_SVH
`define HEIGHTMAP_NORMAL_STENCIL_MACROS_SVH
`ifndef SYNTH
`define HNS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define HNS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HNS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define HNS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/hns_pkg.sv
// ----------------------------------------------------------------------------
// hns_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package hns_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int CNT_W       = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_W       = 16;
  localparam int CFG_COL_W   = 11;
  localparam int CFG_DATA_W  = 16;
  localparam int HEIGHT_W    = 16;
  localparam int POINT_COL_W = 10;
  localparam int NORM_W      = 16;
  localparam int NORMY_W     = 15;

  localparam int TWO_Q10     = 2048;
  localparam int UNIT_Q14    = 16384;
  localparam int FRAC_SHIFT  = 28;
  localparam int SQRT_STEPS  = 32;
  localparam int DIV_STEPS   = 20;
  localparam int ITER_W      = $clog2(SQRT_STEPS);
  localparam int NUM_W       = HEIGHT_W + FRAC_SHIFT + 1;

  localparam logic [CFG_COL_W-1:0] COLS_RESET = 11'd1024;
  localparam logic [ROW_W-1:0]     ROWS_RESET = 16'd1024;

  localparam logic CFG_GRID_COLUMNS = 1'b0;
  localparam logic CFG_GRID_ROWS    = 1'b1;

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  localparam logic [1:0] JOB_ABOVE = 2'd0;
  localparam logic [1:0] JOB_LEFT  = 2'd1;
  localparam logic [1:0] JOB_SELF  = 2'd2;

  typedef struct packed {
    logic accept;
    logic rd_a;
    logic rd_b;
    logic update;
    logic load;
    logic sq1;
    logic sq2;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic div_store;
    logic emit;
  } hns_cmd_t;

  typedef struct packed {
    logic has_job;
    logic more_jobs;
    logic sqrt_last;
    logic div_last;
    logic comp_last;
    logic out_free;
  } hns_status_t;

endpackage

### rtl/hns_ctrl.sv
// ----------------------------------------------------------------------------
// hns_ctrl
// Sequencer: fetch stencil, update line buffers, normalize each result.
// ----------------------------------------------------------------------------
module hns_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  hns_pkg::hns_status_t status,
  output hns_pkg::hns_cmd_t    cmd
);
  import hns_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RDA  = 4'd1;
  localparam logic [3:0] ST_RDB  = 4'd2;
  localparam logic [3:0] ST_UPD  = 4'd3;
  localparam logic [3:0] ST_LOAD = 4'd4;
  localparam logic [3:0] ST_SQ1  = 4'd5;
  localparam logic [3:0] ST_SQ2  = 4'd6;
  localparam logic [3:0] ST_SQRT = 4'd7;
  localparam logic [3:0] ST_DIVI = 4'd8;
  localparam logic [3:0] ST_DIVS = 4'd9;
  localparam logic [3:0] ST_DIVE = 4'd10;
  localparam logic [3:0] ST_EMIT = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_RDA;
        end
      end
      ST_RDA: begin
        cmd.rd_a   = 1'b1;
        state_next = ST_RDB;
      end
      ST_RDB: begin
        cmd.rd_b   = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_next = status.has_job ? ST_LOAD : ST_IDLE;
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_SQ1;
      end
      ST_SQ1: begin
        cmd.sq1    = 1'b1;
        state_next = ST_SQ2;
      end
      ST_SQ2: begin
        cmd.sq2    = 1'b1;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (status.sqrt_last) state_next = ST_DIVI;
      end
      ST_DIVI: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIVS;
      end
      ST_DIVS: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_DIVE;
      end
      ST_DIVE: begin
        cmd.div_store = 1'b1;
        state_next    = status.comp_last ? ST_EMIT : ST_DIVI;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = status.more_jobs ? ST_LOAD : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule

### rtl/hns_dp.sv
// ----------------------------------------------------------------------------
// hns_dp
// Line buffers, counters, stencil operands, square root and divider.
// ----------------------------------------------------------------------------
module hns_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  hns_pkg::hns_cmd_t                   cmd,
  output hns_pkg::hns_status_t                status,
  input  logic [hns_pkg::CNT_W-1:0]           cols,
  input  logic [hns_pkg::ROW_W-1:0]           rows,
  input  logic signed [hns_pkg::HEIGHT_W-1:0] sample_height,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [hns_pkg::POINT_COL_W-1:0]     point_column,
  output logic [hns_pkg::ROW_W-1:0]           point_row,
  output logic signed [hns_pkg::HEIGHT_W-1:0] point_height,
  output logic signed [hns_pkg::NORM_W-1:0]   normal_x,
  output logic [hns_pkg::NORMY_W-1:0]         normal_y,
  output logic signed [hns_pkg::NORM_W-1:0]   normal_z,
  output logic                                run_last,
  output logic                                frame_done
);
  import hns_pkg::*;

  logic [HEIGHT_W-1:0] older_mem [MAX_COLUMNS];
  logic [HEIGHT_W-1:0] newer_mem [MAX_COLUMNS];
  logic [COL_W-1:0]    older_addr, newer_addr;
  logic [HEIGHT_W-1:0] older_rd, newer_rd;

  logic [COL_W-1:0]    column_count;
  logic [ROW_W-1:0]    row_count;
  logic [HEIGHT_W-1:0] prior0, prior1;

  logic [COL_W-1:0]    c_eff, c_q;
  logic [ROW_W-1:0]    r_eff, r_q;
  logic [CNT_W-1:0]    cols_q;
  logic [ROW_W-1:0]    rows_q;
  logic signed [HEIGHT_W-1:0] s_q, yn, oc, ol, on, p0, p1;

  logic [2:0]          job_mask, jmask, pick_bit;
  logic [1:0]          pick;
  logic                last_row, last_col, wrap_col, wrap_row;

  logic [COL_W-1:0]           op_col;
  logic [ROW_W-1:0]           op_row;
  logic signed [HEIGHT_W-1:0] op_y, op_left, op_right, op_down, op_up;
  logic                       op_done;
  logic signed [HEIGHT_W:0]   dx, dz;

  logic [COL_W-1:0]           job_col;
  logic [ROW_W-1:0]           job_row;
  logic signed [HEIGHT_W-1:0] job_y;
  logic                       job_done, job_last;
  logic [HEIGHT_W-1:0]        mx, mz;
  logic                       sx, sz;
  logic [2*HEIGHT_W-1:0]      lx, lz;
  logic [2*HEIGHT_W+1:0]      lsum;

  logic [63:0]         nrem, res, bitv, sq_t;
  logic [31:0]         sroot;
  logic [ITER_W-1:0]   cnt;
  logic [1:0]          comp;
  logic [HEIGHT_W-1:0] mag;
  logic [NUM_W-1:0]    num;
  logic [31:0]         rem;
  logic [32:0]         rem2;
  logic                ge;
  logic [DIV_STEPS-1:0] qlow, quo;
  logic [NORMY_W-1:0]  qc;
  logic signed [NORM_W-1:0] nx, nz;
  logic [NORMY_W-1:0]  ny;

  always_comb begin
    if (CNT_W'(column_count) >= cols) c_eff = COL_W'(cols - CNT_W'(1));
    else                              c_eff = column_count;
    if (row_count >= rows) r_eff = rows - ROW_W'(1);
    else                   r_eff = row_count;
  end

  assign older_addr = cmd.rd_b ? c_q - COL_W'(1) : c_q;
  assign newer_addr = cmd.rd_b ? c_q + COL_W'(1) : c_q;

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      older_mem[c_q] <= yn;
      newer_mem[c_q] <= s_q;
    end
    older_rd <= older_mem[older_addr];
    newer_rd <= newer_mem[newer_addr];
  end

  assign last_row = (r_q == rows_q - ROW_W'(1));
  assign last_col = (CNT_W'(c_q) == cols_q - CNT_W'(1));
  assign job_mask = {last_row & last_col, last_row & (c_q != '0), r_q != '0};
  assign wrap_col = (CNT_W'(c_q) + CNT_W'(1) >= cols_q);
  assign wrap_row = ({1'b0, r_q} + 17'd1 >= {1'b0, rows_q});

  always_comb begin
    priority if (jmask[0]) pick = JOB_ABOVE;
    else if (jmask[1])     pick = JOB_LEFT;
    else                   pick = JOB_SELF;
  end
  assign pick_bit = 3'b001 << pick;

  always_comb begin
    op_col   = c_q;
    op_row   = r_q;
    op_y     = s_q;
    op_left  = p0;
    op_right = s_q;
    op_down  = yn;
    op_up    = s_q;
    op_done  = 1'b0;
    unique case (pick)
      JOB_ABOVE: begin
        op_row   = r_q - ROW_W'(1);
        op_y     = yn;
        op_left  = (c_q != '0) ? ol : yn;
        op_right = last_col ? yn : on;
        op_down  = (r_q > ROW_W'(1)) ? oc : yn;
        op_up    = s_q;
      end
      JOB_LEFT: begin
        op_col   = c_q - COL_W'(1);
        op_y     = p0;
        op_left  = (c_q > COL_W'(1)) ? p1 : p0;
        op_right = s_q;
        op_down  = ol;
        op_up    = p0;
      end
      JOB_SELF: begin
        op_done  = 1'b1;
      end
      default: op_done = 1'b0;
    endcase
  end

  assign dx = {op_left[HEIGHT_W-1], op_left} - {op_right[HEIGHT_W-1], op_right};
  assign dz = {op_down[HEIGHT_W-1], op_down} - {op_up[HEIGHT_W-1], op_up};

  assign sq_t  = res + bitv;
  assign sroot = res[31:0];
  assign lsum  = (2*HEIGHT_W+2)'(lx) + (2*HEIGHT_W+2)'(lz)
               + (2*HEIGHT_W+2)'(TWO_Q10 * TWO_Q10);

  always_comb begin
    unique case (comp)
      COMP_X:  mag = mx;
      COMP_Y:  mag = HEIGHT_W'(TWO_Q10);
      default: mag = mz;
    endcase
  end
  assign num  = {1'b0, mag, FRAC_SHIFT'(0)} + NUM_W'(sroot >> 1);
  assign rem2 = {rem, qlow[DIV_STEPS-1]};
  assign ge   = (rem2 >= {1'b0, sroot});
  assign qc   = (quo > DIV_STEPS'(UNIT_Q14)) ? NORMY_W'(UNIT_Q14) : quo[NORMY_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      prior0       <= '0;
      prior1       <= '0;
      jmask        <= '0;
      comp         <= COMP_X;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.update) begin
        prior1 <= prior0;
        prior0 <= s_q;
        jmask  <= job_mask;
        if (wrap_col) begin
          column_count <= '0;
          row_count    <= wrap_row ? '0 : r_q + ROW_W'(1);
        end else begin
          column_count <= c_q + COL_W'(1);
          row_count    <= r_q;
        end
      end
      if (cmd.load) begin
        jmask <= jmask & ~pick_bit;
        comp  <= COMP_X;
      end
      if (cmd.div_store) comp <= (comp == COMP_Z) ? COMP_X : comp + 2'd1;
      if (cmd.emit)          out_valid <= 1'b1;
      else if (!out_stall)   out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s_q    <= sample_height;
      c_q    <= c_eff;
      r_q    <= r_eff;
      cols_q <= cols;
      rows_q <= rows;
    end
    if (cmd.rd_b) begin
      yn <= newer_rd;
      oc <= older_rd;
    end
    if (cmd.update) begin
      ol <= older_rd;
      on <= newer_rd;
      p0 <= prior0;
      p1 <= prior1;
    end
    if (cmd.load) begin
      job_col  <= op_col;
      job_row  <= op_row;
      job_y    <= op_y;
      job_done <= op_done;
      job_last <= ((jmask & ~pick_bit) == '0);
      sx       <= dx[HEIGHT_W];
      sz       <= dz[HEIGHT_W];
      mx       <= dx[HEIGHT_W] ? HEIGHT_W'(-dx) : dx[HEIGHT_W-1:0];
      mz       <= dz[HEIGHT_W] ? HEIGHT_W'(-dz) : dz[HEIGHT_W-1:0];
    end
    if (cmd.sq1) begin
      lx <= mx * mx;
      lz <= mz * mz;
    end
    if (cmd.sq2) begin
      nrem <= 64'(lsum) << FRAC_SHIFT;
      res  <= '0;
      bitv <= 64'(1) << 62;
      cnt  <= '0;
    end
    if (cmd.sqrt_step) begin
      if (nrem >= sq_t) begin
        nrem <= nrem - sq_t;
        res  <= (res >> 1) + bitv;
      end else begin
        res  <= res >> 1;
      end
      bitv <= bitv >> 2;
      cnt  <= cnt + ITER_W'(1);
    end
    if (cmd.div_init) begin
      rem  <= 32'(num[NUM_W-1:DIV_STEPS]);
      qlow <= num[DIV_STEPS-1:0];
      quo  <= '0;
      cnt  <= '0;
    end
    if (cmd.div_step) begin
      rem  <= ge ? 32'(rem2 - {1'b0, sroot}) : rem2[31:0];
      qlow <= qlow << 1;
      quo  <= {quo[DIV_STEPS-2:0], ge};
      cnt  <= cnt + ITER_W'(1);
    end
    if (cmd.div_store) begin
      unique case (comp)
        COMP_X:  nx <= sx ? -NORM_W'(qc) : NORM_W'(qc);
        COMP_Y:  ny <= qc;
        default: nz <= sz ? -NORM_W'(qc) : NORM_W'(qc);
      endcase
    end
    if (cmd.emit) begin
      point_column <= POINT_COL_W'(job_col);
      point_row    <= job_row;
      point_height <= job_y;
      normal_x     <= nx;
      normal_y     <= ny;
      normal_z     <= nz;
      run_last     <= job_last;
      frame_done   <= job_done;
    end
  end

  assign status.has_job   = (job_mask != '0);
  assign status.more_jobs = (jmask != '0);
  assign status.sqrt_last = (cnt == ITER_W'(SQRT_STEPS - 1));
  assign status.div_last  = (cnt == ITER_W'(DIV_STEPS - 1));
  assign status.comp_last = (comp == COMP_Z);
  assign status.out_free  = !out_valid || !out_stall;

endmodule

### rtl/heightmap_normal_stencil.sv
// Sequence: a sample first fetches its stencil and updates the line buffers,
// then each result takes a load, two squares, a 32-step square root, three
// divides and an emit; the emit waits while a pending beat is stalled.
// A sample causes 0..3 results; no new sample is taken until all are emitted.
// Reset (rst, synchronous): counters, prior samples, state and output valid clear;
// both registers return to 1024. Line buffers are not cleared.
// ----------------------------------------------------------------------------
// heightmap_normal_stencil
// Central difference unit normals of a raster height grid.
// ----------------------------------------------------------------------------
`include "heightmap_normal_stencil_macros.svh"
module heightmap_normal_stencil (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic                                cfg_index,
  input  logic [hns_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [hns_pkg::HEIGHT_W-1:0] sample_height,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [hns_pkg::POINT_COL_W-1:0]     point_column,
  output logic [hns_pkg::ROW_W-1:0]           point_row,
  output logic signed [hns_pkg::HEIGHT_W-1:0] point_height,
  output logic signed [hns_pkg::NORM_W-1:0]   normal_x,
  output logic [hns_pkg::NORMY_W-1:0]         normal_y,
  output logic signed [hns_pkg::NORM_W-1:0]   normal_z,
  output logic                                run_last,
  output logic                                frame_done
);
  import hns_pkg::*;

  logic [CFG_COL_W-1:0] grid_columns;
  logic [ROW_W-1:0]     grid_rows;
  logic [CNT_W-1:0]     cols;
  logic [ROW_W-1:0]     rows;
  hns_cmd_t             cmd;
  hns_status_t          status;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= COLS_RESET;
      grid_rows    <= ROWS_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_GRID_COLUMNS: grid_columns <= cfg_data[CFG_COL_W-1:0];
        CFG_GRID_ROWS:    grid_rows    <= cfg_data[ROW_W-1:0];
        default:          grid_rows    <= grid_rows;
      endcase
    end
  end

  always_comb begin
    priority if (int'(grid_columns) < 2) cols = CNT_W'(2);
    else if (int'(grid_columns) > MAX_COLUMNS) cols = CNT_W'(MAX_COLUMNS);
    else cols = CNT_W'(grid_columns);
    rows = (grid_rows < ROW_W'(2)) ? ROW_W'(2) : grid_rows;
  end

  hns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  hns_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cols          (cols),
    .rows          (rows),
    .sample_height (sample_height),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .point_column  (point_column),
    .point_row     (point_row),
    .point_height  (point_height),
    .normal_x      (normal_x),
    .normal_y      (normal_y),
    .normal_z      (normal_z),
    .run_last      (run_last),
    .frame_done    (frame_done)
  );

  `HNS_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "not busy")
  `HNS_ASSERT_IMPLY(a_emit_has_room, clk, rst, cmd.emit, status.out_free, "beat overwritten")
  `HNS_ASSERT_NEXT(a_emit_shows_valid, clk, rst, cmd.emit, out_valid, "result not valid")
  `HNS_ASSERT_IMPLY(a_stall_while_solving, clk, rst, cmd.sqrt_step || cmd.div_step, in_stall, "open")

endmodule

### tb/sv/tb_heightmap_normal_stencil.sv
// ----------------------------------------------------------------------------
// tb_heightmap_normal_stencil
// Streams grid frames of height samples into the normal stencil block and
// checks every result beat against a cycle-free predictor of the stencil and
// the fixed point normalization, under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_heightmap_normal_stencil;
  timeunit 1ns;
  timeprecision 1ps;
  import hns_pkg::*;

  typedef struct packed {
    logic [POINT_COL_W-1:0]     col;
    logic [ROW_W-1:0]           row;
    logic signed [HEIGHT_W-1:0] height;
    logic signed [NORM_W-1:0]   nx;
    logic [NORMY_W-1:0]         ny;
    logic signed [NORM_W-1:0]   nz;
    logic                       last;
    logic                       done;
  } point_t;

  typedef struct {
    bit   cfg;
    int   cols;
    int   rows;
    logic signed [HEIGHT_W-1:0] h;
    bit   flat;
  } stim_t;

  logic clk, rst;
  logic cfg_write_en, cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [HEIGHT_W-1:0] sample_height;
  logic [POINT_COL_W-1:0] point_column;
  logic [ROW_W-1:0] point_row;
  logic signed [HEIGHT_W-1:0] point_height;
  logic signed [NORM_W-1:0] normal_x, normal_z;
  logic [NORMY_W-1:0] normal_y;
  logic run_last, frame_done;

  heightmap_normal_stencil uut (.*);

  point_t expected_points[$];
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  // predictor state
  int grid_cols = 1024, grid_rows = 1024;
  logic signed [HEIGHT_W-1:0] older_row[MAX_COLUMNS];
  logic signed [HEIGHT_W-1:0] newer_row[MAX_COLUMNS];
  int col_cnt = 0, row_cnt = 0;
  logic signed [HEIGHT_W-1:0] prev0 = 0, prev1 = 0;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint unit_comp(longint v, logic [63:0] s);
    logic [63:0] mag, q;
    mag = (v < 0) ? -v : v;
    q = ((mag << FRAC_SHIFT) + (s >> 1)) / s;
    if (q > UNIT_Q14) q = UNIT_Q14;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic point_t surface_point(int c, int r, int y, int lf, int rt,
                                           int dn, int up, bit done);
    point_t p;
    longint dx, dz;
    logic [63:0] len2, s;
    dx = lf - rt;
    dz = dn - up;
    len2 = dx * dx + TWO_Q10 * TWO_Q10 + dz * dz;
    s = int_sqrt(len2 << FRAC_SHIFT);
    if (s == 0) s = 1;
    p.col = c;
    p.row = r;
    p.height = y;
    p.nx = unit_comp(dx, s);
    p.ny = unit_comp(TWO_Q10, s);
    p.nz = unit_comp(dz, s);
    p.last = 1'b0;
    p.done = done;
    return p;
  endfunction

  function automatic void predict_sample(logic signed [HEIGHT_W-1:0] h, bit flat);
    point_t pts[$];
    int cols, rows, c, r, y;
    cols = grid_cols < 2 ? 2 : (grid_cols > MAX_COLUMNS ? MAX_COLUMNS : grid_cols);
    rows = grid_rows < 2 ? 2 : grid_rows;
    c = col_cnt >= cols ? cols - 1 : col_cnt;
    r = row_cnt >= rows ? rows - 1 : row_cnt;
    if (r >= 1) begin
      y = newer_row[c];
      pts = {pts, surface_point(c, r - 1, y, c > 0 ? int'(older_row[c-1]) : y,
                                c < cols - 1 ? int'(newer_row[c+1]) : y,
                                r > 1 ? int'(older_row[c]) : y, h, 1'b0)};
      if (r == rows - 1) begin
        if (c >= 1)
          pts = {pts, surface_point(c - 1, r, prev0, c > 1 ? int'(prev1) : int'(prev0),
                                    h, older_row[c-1], prev0, 1'b0)};
        if (c == cols - 1)
          pts = {pts, surface_point(c, r, h, prev0, h, newer_row[c], h, 1'b1)};
      end
      pts[pts.size()-1].last = 1'b1;
    end
    foreach (pts[i]) begin
      if (flat) begin
        pts[i].nx = 0;
        pts[i].ny = UNIT_Q14;
        pts[i].nz = 0;
      end
      expected_points = {expected_points, pts[i]};
    end
    older_row[c] = newer_row[c];
    newer_row[c] = h;
    prev1 = prev0;
    prev0 = h;
    if (c + 1 >= cols) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= rows) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
      row_cnt = r;
    end
  endfunction

  always @(negedge clk) begin
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    point_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{point_column, point_row, point_height, normal_x, normal_y, normal_z,
              run_last, frame_done};
      if (expected_points.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: %p", got);
      end else begin
        want = expected_points.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch col/row exp %0d/%0d got %0d/%0d h %0d/%0d ",
                      "n exp %0d %0d %0d got %0d %0d %0d last %b/%b done %b/%b"},
                     want.col, want.row, got.col, got.row, want.height, got.height,
                     want.nx, want.ny, want.nz, got.nx, got.ny, got.nz,
                     want.last, got.last, want.done, got.done);
        end
      end
    end
  end

  task automatic drain_results();
    wait (expected_points.size() == 0);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_grid(int cols, int rows);
    drain_results();
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= CFG_GRID_COLUMNS;
    cfg_data <= CFG_DATA_W'(cols);
    @(negedge clk);
    cfg_index <= CFG_GRID_ROWS;
    cfg_data <= CFG_DATA_W'(rows);
    @(negedge clk);
    cfg_write_en <= 1'b0;
    grid_cols = cols & 16'h7FF;
    grid_rows = rows & 16'hFFFF;
  endtask

  task automatic send_sample(logic signed [HEIGHT_W-1:0] h, bit flat);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample_height <= h;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    predict_sample(h, flat);
  endtask

  task automatic set_mode(int m);
    case (m % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 77; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 77; end
      default: begin send_idle_pct = 11; stall_pct = 11; end
    endcase
  endtask

  stim_t directed[$] = '{
    '{1, 2, 2, 0, 0},
    '{0, 0, 0, 16'sd0, 1}, '{0, 0, 0, 16'sd0, 1}, '{0, 0, 0, 16'sd0, 1},
    '{0, 0, 0, 16'sd0, 1},
    '{1, 3, 3, 0, 0},
    '{0, 0, 0, 16'sh7FFF, 0}, '{0, 0, 0, 16'sh8000, 0}, '{0, 0, 0, 16'sd0, 0},
    '{0, 0, 0, 16'sh8000, 0}, '{0, 0, 0, 16'sh7FFF, 0}, '{0, 0, 0, 16'sh8000, 0},
    '{0, 0, 0, 16'sd0, 0}, '{0, 0, 0, 16'sh7FFF, 0}, '{0, 0, 0, -16'sd1, 0},
    '{1, 1, 0, 0, 0},
    '{0, 0, 0, 16'sh7FFF, 1}, '{0, 0, 0, 16'sh7FFF, 1}, '{0, 0, 0, 16'sh7FFF, 1},
    '{0, 0, 0, 16'sh7FFF, 1},
    '{1, 2, 65535, 0, 0},
    '{0, 0, 0, 16'sd5, 0}, '{0, 0, 0, -16'sd5, 0},
    '{1, 2, 2, 0, 0},
    '{0, 0, 0, 16'sd100, 0}, '{0, 0, 0, -16'sd100, 0}
  };

  initial begin
    int sent, phase, cols, rows, frames, base;
    logic signed [HEIGHT_W-1:0] h;
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index = CFG_GRID_COLUMNS;
    cfg_data = '0;
    in_valid = 1'b0;
    sample_height = '0;
    out_stall = 1'b0;
    foreach (older_row[i]) begin
      older_row[i] = 0;
      newer_row[i] = 0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].cfg) begin
        @(negedge clk);
        in_valid <= 1'b0;
        write_grid(directed[i].cols, directed[i].rows);
      end else begin
        send_sample(directed[i].h, directed[i].flat);
      end
    end

    sent = 0;
    phase = 0;
    while (sent < 190) begin
      @(negedge clk);
      in_valid <= 1'b0;
      cols = ($urandom_range(3) == 0) ? 2 : $urandom_range(2, 9);
      rows = $urandom_range(2, 5);
      write_grid(cols, rows);
      set_mode(phase);
      frames = $urandom_range(1, 2);
      repeat (frames * cols * rows) begin
        if ($urandom_range(1)) begin
          h = $urandom;
        end else begin
          base = $urandom_range(4000);
          h = base - 2000;
        end
        send_sample(h, 0);
        sent++;
      end
      phase++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    drain_results();
    if (errors == 0 && expected_points.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
